// ----- hdl/tpwr_pkg.sv -----
// Shared types and codes for the trie prefix word replacer.
`timescale 1ns / 1ps
`default_nettype none

package tpwr_pkg;

	// Request kinds carried in req_type.
	localparam logic REQ_DICT = 1'b0;
	localparam logic REQ_SENTENCE = 1'b1;

	// Symbol code of a space.
	localparam logic [4:0] SPACE_CODE = 5'd26;

	// Word matching modes.
	localparam logic [1:0] MODE_MATCHING = 2'd0;
	localparam logic [1:0] MODE_FOUND = 2'd1;
	localparam logic [1:0] MODE_PASS = 2'd2;

	// One input beat.
	typedef struct packed {
		logic req_type;
		logic [4:0] symbol;
		logic root_last;
		logic sentence_last;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic emit;
		logic [4:0] out_symbol;
		logic out_last;
		logic pool_full;
	} out_item_t;

endpackage

`default_nettype wire

// ----- hdl/trie_prefix_word_replacer.sv -----
// Top level of the trie prefix word replacer: link memory, cursors and result register.
//
// Channel  Direction  Handshake            Beat
// in       input      in_valid / in_stall   tpwr_pkg::in_item_t
// out      output     out_valid / out_stall tpwr_pkg::out_item_t
//
// Each item first reads the child link of the current trie node from the link memory,
// then updates that entry and the cursors and loads the result. No new item is taken
// while one is in the update stage. After reset a clearing pass zeroes every entry of
// the link memory, during which no item is accepted.
// A stalled result waits in the output register; one more item is taken meanwhile and
// holds in the update stage until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module trie_prefix_word_replacer #(
	parameter int NODE_COUNT = 1024,
	parameter int ALPHABET_SIZE = 26
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire tpwr_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output tpwr_pkg::out_item_t out_data
);

	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int FW = $clog2(NODE_COUNT + 1);
	localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = NW + 1;

	// Link memory: each entry holds {end mark of the child, child node}.
	logic [LW-1:0] link_mem [DEPTH];
	logic [LW-1:0] rdata_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;
	logic [AW-1:0] rd_addr;

	// Clearing pass after reset.
	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Update stage.
	logic s1_valid_q;
	tpwr_pkg::in_item_t item_s1;
	logic [AW-1:0] addr_s1;
	logic s1_done;
	logic in_accept;

	// Trie state.
	logic [FW-1:0] free_q;
	logic [NW-1:0] ins_cur_q;
	logic [AW-1:0] ins_link_q;
	logic drop_q;
	logic [NW-1:0] match_q;
	logic [1:0] mode_q;
	logic overflow_q;

	// Output register.
	logic out_valid_q;
	tpwr_pkg::out_item_t out_data_q;

	// Decoded update-stage values.
	logic letter_s1;
	logic [NW-1:0] rd_child;
	logic rd_mark;
	logic have_free;
	logic letter_take;
	logic new_alloc;
	logic drop_now;
	logic drop_next;
	logic [NW-1:0] cur_mid;
	logic [AW-1:0] link_mid;
	logic mark_wr;
	logic in_letter;
	logic [NW-1:0] in_node;
	logic [NW-1:0] match_next;
	logic [1:0] mode_next;
	logic emit_next;
	logic overflow_next;
	tpwr_pkg::out_item_t result;

	// Handshake.
	assign in_stall = clr_busy_q || s1_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign s1_done = s1_valid_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// Read address of the child link for the incoming symbol.
	assign in_letter = (32'(in_data.symbol) < ALPHABET_SIZE) &&
		(in_data.symbol != tpwr_pkg::SPACE_CODE);
	assign in_node = (in_data.req_type == tpwr_pkg::REQ_SENTENCE) ? match_q : ins_cur_q;
	assign rd_addr = in_letter ?
		AW'(AW'(in_node) * AW'(ALPHABET_SIZE) + AW'(in_data.symbol)) : '0;

	// Memory read and write ports.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rdata_q <= link_mem[rd_addr];
		end
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
	end

	// Dictionary insert decode.
	assign letter_s1 = (32'(item_s1.symbol) < ALPHABET_SIZE) &&
		(item_s1.symbol != tpwr_pkg::SPACE_CODE);
	assign rd_child = rdata_q[NW-1:0];
	assign rd_mark = rdata_q[NW];
	assign have_free = free_q < FW'(NODE_COUNT);
	assign letter_take = !drop_q && letter_s1;
	assign new_alloc = letter_take && (rd_child == '0) && have_free;
	assign drop_now = letter_take && (rd_child == '0) && !have_free;
	assign drop_next = drop_q || drop_now;
	assign cur_mid = (letter_take && !drop_now) ?
		(new_alloc ? free_q[NW-1:0] : rd_child) : ins_cur_q;
	assign link_mid = (letter_take && !drop_now) ? addr_s1 : ins_link_q;
	assign mark_wr = item_s1.root_last && !drop_next && (cur_mid != '0);

	// Sentence matching decode.
	always_comb begin
		match_next = match_q;
		mode_next = mode_q;
		emit_next = 1'b1;
		if (item_s1.symbol == tpwr_pkg::SPACE_CODE) begin
			match_next = '0;
			mode_next = tpwr_pkg::MODE_MATCHING;
		end else if (mode_q == tpwr_pkg::MODE_FOUND) begin
			emit_next = 1'b0;
		end else if (mode_q == tpwr_pkg::MODE_MATCHING) begin
			if (!letter_s1 || rd_child == '0) begin
				mode_next = tpwr_pkg::MODE_PASS;
			end else begin
				match_next = rd_child;
				if (rd_mark) begin
					mode_next = tpwr_pkg::MODE_FOUND;
				end
			end
		end
		if (item_s1.sentence_last) begin
			match_next = '0;
			mode_next = tpwr_pkg::MODE_MATCHING;
		end
	end

	// Result of the item in the update stage.
	always_comb begin
		overflow_next = overflow_q;
		if (item_s1.req_type == tpwr_pkg::REQ_DICT) begin
			overflow_next = overflow_q || drop_now;
			result.emit = 1'b0;
			result.out_symbol = '0;
			result.out_last = 1'b0;
		end else begin
			result.emit = emit_next;
			result.out_symbol = item_s1.symbol;
			result.out_last = item_s1.sentence_last;
		end
		result.pool_full = overflow_next;
	end

	// Memory write: clearing pass, new link, or end mark on the link into the root's last node.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = link_mid;
		mem_wdata = {mark_wr, cur_mid};
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (s1_done && item_s1.req_type == tpwr_pkg::REQ_DICT) begin
			mem_we = new_alloc || mark_wr;
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Update stage payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
			addr_s1 <= rd_addr;
		end
	end

	// Trie state and stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			free_q <= FW'(1);
			ins_cur_q <= '0;
			drop_q <= 1'b0;
			match_q <= '0;
			mode_q <= tpwr_pkg::MODE_MATCHING;
			overflow_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_done) begin
				out_valid_q <= 1'b1;
				overflow_q <= overflow_next;
				if (item_s1.req_type == tpwr_pkg::REQ_DICT) begin
					if (new_alloc) begin
						free_q <= free_q + FW'(1);
					end
					if (item_s1.root_last) begin
						ins_cur_q <= '0;
						drop_q <= 1'b0;
					end else begin
						ins_cur_q <= cur_mid;
						drop_q <= drop_next;
					end
				end else begin
					match_q <= match_next;
					mode_q <= mode_next;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Link address of the insert cursor and the result payload.
	always_ff @(posedge clk) begin
		if (s1_done) begin
			out_data_q <= result;
			if (item_s1.req_type == tpwr_pkg::REQ_DICT) begin
				ins_link_q <= link_mid;
			end
		end
	end

`ifndef SYNTH
	// The update stage stays empty while the memory is being cleared.
	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_valid_q)
		else $error("item in update stage during clearing pass");

	// An accepted item occupies the update stage in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> s1_valid_q)
		else $error("accepted item lost");

	// The node counter never passes the pool size.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FW'(NODE_COUNT))
		else $error("node counter beyond pool");

	// The insert cursor only points at allocated nodes.
	a_cursor_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		FW'(ins_cur_q) < free_q)
		else $error("insert cursor at unallocated node");

	// The overflow flag is sticky.
	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");
`endif

endmodule

`default_nettype wire

// ----- bench/trie_prefix_word_replacer_test.sv -----
// Self-checking testbench for the trie prefix word replacer.
`timescale 1ns / 1ps

module trie_prefix_word_replacer_test;

	localparam int NODES = 1024;
	localparam int ALPHA = 26;
	localparam int NARROW_HI = 3;
	localparam int MAX_ROOTS = 256;
	localparam int MAX_LEN = 16;
	localparam int FILL_LEN = 14;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 500000;

	// Letters and odd symbols used by the directed table.
	localparam logic [4:0] L_A = 5'd0;
	localparam logic [4:0] L_C = 5'd2;
	localparam logic [4:0] L_T = 5'd19;
	localparam logic [4:0] L_Z = 5'd25;
	localparam logic [4:0] BAD_SYM_LO = 5'd27;
	localparam logic [4:0] BAD_SYM_HI = 5'd31;
	localparam logic [4:0] SPC = tpwr_pkg::SPACE_CODE;
	localparam tpwr_pkg::out_item_t DICT_RESULT = '0;

	typedef struct {
		tpwr_pkg::in_item_t beat;
		logic typed;
		tpwr_pkg::out_item_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	tpwr_pkg::in_item_t in_data = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	tpwr_pkg::out_item_t out_data;

	// Shadow trie and matcher state.
	bit [9:0] trie_link [NODES * ALPHA];
	bit word_end [NODES];
	int unsigned next_free = 1;
	int unsigned ins_node = 0;
	bit ins_dropped = 1'b0;
	int unsigned scan_node = 0;
	logic [1:0] scan_mode = tpwr_pkg::MODE_MATCHING;
	bit pool_overflow = 1'b0;

	tpwr_pkg::out_item_t expected_results [$];
	tpwr_pkg::out_item_t oldest_result;
	step_t directed_steps [$];

	// Roots already sent, reused to build sentence words that hit the trie.
	logic [4:0] root_text [MAX_ROOTS][MAX_LEN];
	int root_size [MAX_ROOTS];
	int root_head = 0;
	int root_fill = 0;

	int faults = 0;
	int beats_sent = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;
	int take_stall_pct = 0;
	int goal;

	trie_prefix_word_replacer #(
		.NODE_COUNT(NODES),
		.ALPHABET_SIZE(ALPHA)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result of one beat and advances the shadow state.
	function automatic tpwr_pkg::out_item_t predict_beat(input tpwr_pkg::in_item_t it);
		tpwr_pkg::out_item_t r;
		int unsigned child;
		r = '0;
		if (it.req_type == tpwr_pkg::REQ_DICT) begin
			if (!ins_dropped && it.symbol < ALPHA) begin
				child = trie_link[ins_node * ALPHA + it.symbol];
				if (child == 0) begin
					if (next_free < NODES) begin
						child = next_free;
						next_free++;
						trie_link[ins_node * ALPHA + it.symbol] = 10'(child);
					end else begin
						// No free node: the rest of this root is skipped.
						pool_overflow = 1'b1;
						ins_dropped = 1'b1;
					end
				end
				if (!ins_dropped)
					ins_node = child;
			end
			if (it.root_last) begin
				if (!ins_dropped && ins_node != 0)
					word_end[ins_node] = 1'b1;
				ins_node = 0;
				ins_dropped = 1'b0;
			end
		end else begin
			r.out_symbol = it.symbol;
			r.out_last = it.sentence_last;
			if (it.symbol == tpwr_pkg::SPACE_CODE) begin
				r.emit = 1'b1;
				scan_node = 0;
				scan_mode = tpwr_pkg::MODE_MATCHING;
			end else if (scan_mode != tpwr_pkg::MODE_FOUND) begin
				r.emit = 1'b1;
				if (scan_mode == tpwr_pkg::MODE_MATCHING) begin
					child = 0;
					if (it.symbol < ALPHA)
						child = trie_link[scan_node * ALPHA + it.symbol];
					if (child == 0) begin
						scan_mode = tpwr_pkg::MODE_PASS;
					end else begin
						scan_node = child;
						if (word_end[child])
							scan_mode = tpwr_pkg::MODE_FOUND;
					end
				end
			end
			if (it.sentence_last) begin
				scan_node = 0;
				scan_mode = tpwr_pkg::MODE_MATCHING;
			end
		end
		r.pool_full = pool_overflow;
		return r;
	endfunction

	// The flag that the other request kind ignores is random.
	function automatic tpwr_pkg::in_item_t dict_beat(input logic [4:0] sym, input logic last);
		tpwr_pkg::in_item_t b;
		b.req_type = tpwr_pkg::REQ_DICT;
		b.symbol = sym;
		b.root_last = last;
		b.sentence_last = 1'($urandom_range(1));
		return b;
	endfunction

	function automatic tpwr_pkg::in_item_t sentence_beat(input logic [4:0] sym,
			input logic last);
		tpwr_pkg::in_item_t b;
		b.req_type = tpwr_pkg::REQ_SENTENCE;
		b.symbol = sym;
		b.root_last = 1'($urandom_range(1));
		b.sentence_last = last;
		return b;
	endfunction

	// Appends one row to the directed table.
	function automatic void add_step(input tpwr_pkg::in_item_t beat, input logic typed,
			input tpwr_pkg::out_item_t want);
		step_t s;
		s.beat = beat;
		s.typed = typed;
		s.want = want;
		directed_steps = {directed_steps, s};
	endfunction

	function automatic void log_fault(input string msg);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// Offers one beat after a random gap and records its result once accepted.
	task automatic send_beat(input tpwr_pkg::in_item_t beat, input logic typed,
			input tpwr_pkg::out_item_t want);
		tpwr_pkg::out_item_t predicted;
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = predict_beat(beat);
		expected_results = {expected_results, (typed ? want : predicted)};
		beats_sent++;
	endtask

	// Sends one root: the start of a known root, then fresh letters.
	task automatic send_root(input int base_len, input int extra, input int hi);
		logic [4:0] text [$];
		logic [4:0] s;
		int pick;
		int slot;
		int n;
		if (base_len > 0 && root_fill > 0) begin
			pick = $urandom_range(root_fill - 1);
			for (int k = 0; k < base_len && k < root_size[pick]; k++)
				text = {text, root_text[pick][k]};
		end
		for (int k = 0; k < extra; k++) begin
			// Now and then a symbol that is not a letter, which the trie skips.
			if ($urandom_range(19) == 0)
				s = 5'($urandom_range(31, 26));
			else
				s = 5'($urandom_range(hi));
			text = {text, s};
		end
		if (text.size() == 0) begin
			// Empty root: only the end marker, on a symbol that is not a letter.
			send_beat(dict_beat(5'($urandom_range(31, 26)), 1'b1), 1'b0, DICT_RESULT);
		end else begin
			slot = root_head;
			n = 0;
			for (int k = 0; k < text.size(); k++) begin
				send_beat(dict_beat(text[k], k == text.size() - 1), 1'b0, DICT_RESULT);
				if (text[k] < ALPHA && n < MAX_LEN) begin
					root_text[slot][n] = text[k];
					n++;
				end
			end
			if (n > 0) begin
				root_size[slot] = n;
				root_head = (root_head + 1) % MAX_ROOTS;
				if (root_fill < MAX_ROOTS)
					root_fill++;
			end
		end
	endtask

	// Sends one sentence of words built mostly around known roots.
	task automatic send_sentence(input int words, input int hi);
		logic [4:0] line [$];
		int kind;
		int pick;
		int len;
		if ($urandom_range(7) == 0)
			line = {line, SPC};
		for (int w = 0; w < words; w++) begin
			if (w > 0) begin
				line = {line, SPC};
				if ($urandom_range(9) == 0)
					line = {line, SPC};
			end
			kind = $urandom_range(9);
			pick = (root_fill > 0) ? $urandom_range(root_fill - 1) : 0;
			if (kind < 5 && root_fill > 0) begin
				// A root followed by a short random tail.
				for (int k = 0; k < root_size[pick]; k++)
					line = {line, root_text[pick][k]};
				len = $urandom_range(3);
				for (int k = 0; k < len; k++)
					line = {line, 5'($urandom_range(hi))};
			end else if (kind < 7 && root_fill > 0) begin
				// A prefix of a root, possibly too short to match.
				len = $urandom_range(1, root_size[pick]);
				for (int k = 0; k < len; k++)
					line = {line, root_text[pick][k]};
			end else if (kind == 9) begin
				// Any symbol code at all, letters or not.
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					line = {line, 5'($urandom_range(31))};
			end else begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					line = {line, 5'($urandom_range(hi))};
			end
		end
		if ($urandom_range(7) == 0)
			line = {line, SPC};
		for (int k = 0; k < line.size(); k++)
			send_beat(sentence_beat(line[k], k == line.size() - 1), 1'b0, DICT_RESULT);
	endtask

	// One random root or sentence, on a narrow alphabet most of the time.
	task automatic send_random_chunk();
		int hi;
		hi = ($urandom_range(3) == 0) ? ALPHA - 1 : NARROW_HI;
		if ($urandom_range(9) < 3) begin
			if ($urandom_range(1) == 0)
				send_root(0, $urandom_range(4), hi);
			else
				send_root($urandom_range(1, 4), $urandom_range(3), hi);
		end else begin
			send_sentence($urandom_range(1, 5), hi);
		end
	endtask

	// Receiver stall, changed on the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < take_stall_pct);
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				log_fault($sformatf({"unexpected result beat: emit=%0d symbol=%0d ",
					"last=%0d pool_full=%0d"},
					out_data.emit, out_data.out_symbol, out_data.out_last,
					out_data.pool_full));
			end else begin
				oldest_result = expected_results.pop_front();
				if (out_data.emit !== oldest_result.emit ||
						out_data.out_symbol !== oldest_result.out_symbol ||
						out_data.out_last !== oldest_result.out_last ||
						out_data.pool_full !== oldest_result.pool_full) begin
					log_fault($sformatf({"result mismatch: expected emit=%0d symbol=%0d last=%0d ",
						"pool_full=%0d, got emit=%0d symbol=%0d last=%0d pool_full=%0d"},
						oldest_result.emit, oldest_result.out_symbol, oldest_result.out_last,
						oldest_result.pool_full, out_data.emit, out_data.out_symbol,
						out_data.out_last, out_data.pool_full));
				end
			end
		end
	end

	// Run limit, covering the link clearing pass after reset.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("trie_prefix_word_replacer regression: fail");
			$finish;
		end
	end

	initial begin
		// Directed table: empty trie, empty root, a root and its shorter prefix root,
		// letter extremes and a space inside a root, then sentences that hit found, suppressed,
		// exact-root and pass-through words, one of them with an odd code inside.
		add_step(sentence_beat(L_A, 1'b0), 1'b1, tpwr_pkg::out_item_t'{1'b1, L_A, 1'b0, 1'b0});
		add_step(sentence_beat(SPC, 1'b1), 1'b1, tpwr_pkg::out_item_t'{1'b1, SPC, 1'b1, 1'b0});
		add_step(dict_beat(BAD_SYM_HI, 1'b1), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_C, 1'b0), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_A, 1'b0), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_T, 1'b1), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_C, 1'b0), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_A, 1'b1), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_Z, 1'b0), 1'b1, DICT_RESULT);
		add_step(dict_beat(SPC, 1'b0), 1'b1, DICT_RESULT);
		add_step(dict_beat(L_Z, 1'b1), 1'b1, DICT_RESULT);
		add_step(sentence_beat(L_C, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_A, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_T, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_T, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(SPC, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_C, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_A, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(SPC, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_Z, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(BAD_SYM_LO, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_Z, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(SPC, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_Z, 1'b0), 1'b0, DICT_RESULT);
		add_step(sentence_beat(L_Z, 1'b1), 1'b0, DICT_RESULT);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Slow receiver first.
		send_gap_pct = 17;
		take_stall_pct = 80;
		foreach (directed_steps[i])
			send_beat(directed_steps[i].beat, directed_steps[i].typed, directed_steps[i].want);
		while (beats_sent < 350)
			send_random_chunk();

		// Slow sender.
		send_gap_pct = 80;
		take_stall_pct = 17;
		while (beats_sent < 650)
			send_random_chunk();

		// Full rate: fill the node pool with long roots, then keep mixing so that
		// later roots are dropped part way while old ones still match.
		send_gap_pct = 0;
		take_stall_pct = 0;
		while (!pool_overflow)
			send_root(0, FILL_LEN, ALPHA - 1);
		goal = beats_sent + 300;
		while (beats_sent < goal)
			send_random_chunk();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("trie_prefix_word_replacer regression: pass");
		else
			$display("trie_prefix_word_replacer regression: fail");
		$finish;
	end

endmodule
